// File: hw/rtl/pcss_pkg.sv
`timescale 1ns / 1ps

package pcss_pkg;

  localparam int EXT_W  = 6;
  localparam int OP_W   = 3;
  localparam int TONE_W = 3;

  typedef enum logic [OP_W-1:0] {
    OP_REGISTER   = 3'd0,
    OP_UNREGISTER = 3'd1,
    OP_PICKUP     = 3'd2,
    OP_HANGUP     = 3'd3,
    OP_DIAL       = 3'd4
  } op_t;

  typedef enum logic [TONE_W-1:0] {
    TONE_ONHOOK    = 3'd0,
    TONE_RINGING   = 3'd1,
    TONE_DIALTONE  = 3'd2,
    TONE_RINGBACK  = 3'd3,
    TONE_BUSY      = 3'd4,
    TONE_CONNECTED = 3'd5,
    TONE_ERROR     = 3'd6
  } tone_t;

  // One extension table entry.
  typedef struct packed {
    logic             regd;
    tone_t            ls;
    logic             pv;
    logic [EXT_W-1:0] pi;
  } entry_t;

  typedef struct packed {
    logic [EXT_W-1:0] dest;
    tone_t            tone;
    logic [EXT_W-1:0] num;
  } notice_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GET_U,
    ST_GET_E,
    ST_NOTE0,
    ST_NOTE1
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic cap_u;
    logic plan;
    logic note0;
    logic note1;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic go;
    logic more;
  } status_t;

endpackage

// File: hw/rtl/pcss_ctrl.sv
`timescale 1ns / 1ps

module pcss_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  pcss_pkg::status_t  status,
  output pcss_pkg::cmd_t     cmd,
  output logic               busy
);

  pcss_pkg::state_t state_r;
  pcss_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pcss_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b1;
    unique case (state_r)
      pcss_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = pcss_pkg::ST_GET_U;
        end
      end
      pcss_pkg::ST_GET_U: begin
        cmd.cap_u = 1'b1;
        state_nxt = status.go ? pcss_pkg::ST_GET_E : pcss_pkg::ST_IDLE;
      end
      pcss_pkg::ST_GET_E: begin
        cmd.plan  = 1'b1;
        state_nxt = pcss_pkg::ST_NOTE0;
      end
      pcss_pkg::ST_NOTE0: begin
        cmd.note0 = 1'b1;
        state_nxt = status.more ? pcss_pkg::ST_NOTE1 : pcss_pkg::ST_IDLE;
      end
      pcss_pkg::ST_NOTE1: begin
        cmd.note1 = 1'b1;
        state_nxt = pcss_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = pcss_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// File: hw/rtl/pcss_datapath.sv
`timescale 1ns / 1ps

module pcss_datapath #(
  parameter int MAX_EXTENSIONS = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  pcss_pkg::cmd_t               cmd,
  output pcss_pkg::status_t            status,
  input  logic [pcss_pkg::OP_W-1:0]    in_op,
  input  logic [pcss_pkg::EXT_W-1:0]   in_unit,
  input  logic [pcss_pkg::EXT_W-1:0]   in_target,
  output logic                         out_valid,
  output logic [pcss_pkg::EXT_W-1:0]   out_dest_ext,
  output logic [pcss_pkg::TONE_W-1:0]  out_tone,
  output logic [pcss_pkg::EXT_W-1:0]   out_number,
  output logic                         out_last
);

  localparam int EXT_SPAN  = 2 ** pcss_pkg::EXT_W;
  localparam int TBL_DEPTH = (MAX_EXTENSIONS < EXT_SPAN) ? MAX_EXTENSIONS : EXT_SPAN;
  localparam int AW        = $clog2(TBL_DEPTH);

  // Latched event.
  logic [pcss_pkg::OP_W-1:0]  op_r;
  logic [pcss_pkg::EXT_W-1:0] unit_r;
  logic [pcss_pkg::EXT_W-1:0] target_r;

  // Extension table: payload in a memory, a written flag per entry in flops.
  pcss_pkg::entry_t mem_r [TBL_DEPTH];
  logic [TBL_DEPTH-1:0] vld_r;
  pcss_pkg::entry_t rdata_r;
  logic             rvalid_r;
  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  pcss_pkg::entry_t wr_data;
  pcss_pkg::entry_t rd_ent;

  // Captured unit entry and the address of the second entry.
  pcss_pkg::entry_t           ent_u_r;
  logic [pcss_pkg::EXT_W-1:0] e_addr_r;
  logic [pcss_pkg::EXT_W-1:0] e_addr_sel;

  // Plan of writes and notices.
  pcss_pkg::notice_t n0_r, n0_nxt;
  pcss_pkg::notice_t n1_r, n1_nxt;
  logic [1:0]        cnt_r, cnt_nxt;
  pcss_pkg::entry_t  wu_r, wu_nxt;
  pcss_pkg::entry_t  we_r, we_nxt;
  logic              wre_r, wre_nxt;

  logic c_ok;
  logic t_ok;
  logic rel_hit;
  pcss_pkg::notice_t rel_note;
  pcss_pkg::tone_t   rel_ls;
  pcss_pkg::tone_t   s;

  assign rd_ent = rvalid_r ? rdata_r : '0;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r     <= in_op;
      unit_r   <= in_unit;
      target_r <= in_target;
    end
    if (cmd.cap_u) begin
      ent_u_r  <= rd_ent;
      e_addr_r <= e_addr_sel;
    end
  end

  assign status.go = (op_r <= pcss_pkg::OP_W'(pcss_pkg::OP_DIAL)) &&
                     (32'(unit_r) < MAX_EXTENSIONS);
  assign status.more = wre_r || (cnt_r == 2'd2);

  assign e_addr_sel = (op_r == pcss_pkg::OP_W'(pcss_pkg::OP_DIAL)) ? target_r : rd_ent.pi;

  assign rd_en   = cmd.load || cmd.cap_u;
  assign rd_addr = cmd.load ? in_unit[AW-1:0] : e_addr_sel[AW-1:0];

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = unit_r[AW-1:0];
    wr_data = wu_r;
    if (cmd.note0) begin
      wr_en = 1'b1;
    end else if (cmd.note1) begin
      wr_en   = wre_r;
      wr_addr = e_addr_r[AW-1:0];
      wr_data = we_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r  <= mem_r[rd_addr];
      rvalid_r <= vld_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  // The peer leaves a call: it falls back to dial tone or on hook.
  always_comb begin
    rel_hit  = 1'b0;
    rel_ls   = rd_ent.ls;
    rel_note = '{dest: ent_u_r.pi, tone: pcss_pkg::TONE_DIALTONE, num: '0};
    if (rd_ent.ls == pcss_pkg::TONE_CONNECTED || rd_ent.ls == pcss_pkg::TONE_RINGBACK) begin
      rel_hit = 1'b1;
      rel_ls  = pcss_pkg::TONE_DIALTONE;
    end else if (rd_ent.ls == pcss_pkg::TONE_RINGING) begin
      rel_hit       = 1'b1;
      rel_ls        = pcss_pkg::TONE_ONHOOK;
      rel_note.tone = pcss_pkg::TONE_ONHOOK;
      rel_note.num  = ent_u_r.pi;
    end
  end

  assign c_ok = ent_u_r.pv && (32'(ent_u_r.pi) < MAX_EXTENSIONS);
  assign t_ok = 32'(target_r) < MAX_EXTENSIONS;
  assign s    = ent_u_r.ls;

  always_comb begin
    cnt_nxt = 2'd0;
    n0_nxt  = '{dest: unit_r, tone: pcss_pkg::TONE_ONHOOK, num: '0};
    n1_nxt  = '{dest: unit_r, tone: pcss_pkg::TONE_ONHOOK, num: '0};
    wu_nxt  = ent_u_r;
    we_nxt  = rd_ent;
    wre_nxt = 1'b0;
    if (op_r == pcss_pkg::OP_W'(pcss_pkg::OP_REGISTER)) begin
      if (!ent_u_r.regd) begin
        wu_nxt.regd = 1'b1;
        wu_nxt.ls   = pcss_pkg::TONE_ONHOOK;
        wu_nxt.pv   = 1'b0;
        cnt_nxt     = 2'd1;
        n0_nxt.num  = unit_r;
      end
    end else if (ent_u_r.regd) begin
      case (op_r)
        pcss_pkg::OP_W'(pcss_pkg::OP_UNREGISTER): begin
          wu_nxt.regd = 1'b0;
          wu_nxt.ls   = pcss_pkg::TONE_ONHOOK;
          wu_nxt.pv   = 1'b0;
          if (c_ok) begin
            wre_nxt   = 1'b1;
            we_nxt.ls = rel_ls;
            we_nxt.pv = 1'b0;
            if (rel_hit) begin
              cnt_nxt = 2'd1;
              n0_nxt  = rel_note;
            end
          end
        end
        pcss_pkg::OP_W'(pcss_pkg::OP_PICKUP): begin
          cnt_nxt = 2'd1;
          if (s == pcss_pkg::TONE_RINGING && c_ok) begin
            wu_nxt.ls = pcss_pkg::TONE_CONNECTED;
            wre_nxt   = 1'b1;
            we_nxt.ls = pcss_pkg::TONE_CONNECTED;
            cnt_nxt   = 2'd2;
            n0_nxt    = '{dest: unit_r, tone: pcss_pkg::TONE_CONNECTED, num: ent_u_r.pi};
            n1_nxt    = '{dest: ent_u_r.pi, tone: pcss_pkg::TONE_CONNECTED, num: unit_r};
          end else if (s == pcss_pkg::TONE_ONHOOK || s == pcss_pkg::TONE_RINGING) begin
            wu_nxt.ls   = pcss_pkg::TONE_DIALTONE;
            wu_nxt.pv   = 1'b0;
            n0_nxt.tone = pcss_pkg::TONE_DIALTONE;
          end else if (s == pcss_pkg::TONE_CONNECTED) begin
            n0_nxt.tone = pcss_pkg::TONE_CONNECTED;
            n0_nxt.num  = ent_u_r.pv ? ent_u_r.pi : '0;
          end else begin
            n0_nxt.tone = s;
          end
        end
        pcss_pkg::OP_W'(pcss_pkg::OP_HANGUP): begin
          wu_nxt.ls  = pcss_pkg::TONE_ONHOOK;
          wu_nxt.pv  = 1'b0;
          cnt_nxt    = 2'd1;
          n0_nxt.num = unit_r;
          if (c_ok) begin
            wre_nxt   = 1'b1;
            we_nxt.ls = rel_ls;
            we_nxt.pv = 1'b0;
            if (rel_hit) begin
              cnt_nxt = 2'd2;
              n1_nxt  = rel_note;
            end
          end
        end
        pcss_pkg::OP_W'(pcss_pkg::OP_DIAL): begin
          cnt_nxt = 2'd1;
          if (s == pcss_pkg::TONE_DIALTONE) begin
            if (!t_ok || !rd_ent.regd) begin
              wu_nxt.ls   = pcss_pkg::TONE_ERROR;
              n0_nxt.tone = pcss_pkg::TONE_ERROR;
            end else if (rd_ent.ls == pcss_pkg::TONE_ONHOOK) begin
              wu_nxt.ls   = pcss_pkg::TONE_RINGBACK;
              wu_nxt.pv   = 1'b1;
              wu_nxt.pi   = target_r;
              wre_nxt     = 1'b1;
              we_nxt.ls   = pcss_pkg::TONE_RINGING;
              we_nxt.pv   = 1'b1;
              we_nxt.pi   = unit_r;
              cnt_nxt     = 2'd2;
              n0_nxt.tone = pcss_pkg::TONE_RINGBACK;
              n1_nxt      = '{dest: target_r, tone: pcss_pkg::TONE_RINGING, num: '0};
            end else begin
              wu_nxt.ls   = pcss_pkg::TONE_BUSY;
              n0_nxt.tone = pcss_pkg::TONE_BUSY;
            end
          end else if (s == pcss_pkg::TONE_CONNECTED) begin
            n0_nxt.tone = pcss_pkg::TONE_CONNECTED;
            n0_nxt.num  = ent_u_r.pv ? ent_u_r.pi : '0;
          end else if (s == pcss_pkg::TONE_ONHOOK) begin
            n0_nxt.num = unit_r;
          end else begin
            n0_nxt.tone = s;
          end
        end
        default: begin
          cnt_nxt = 2'd0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.plan) begin
      n0_r  <= n0_nxt;
      n1_r  <= n1_nxt;
      cnt_r <= cnt_nxt;
      wu_r  <= wu_nxt;
      we_r  <= we_nxt;
      wre_r <= wre_nxt;
    end
  end

  assign out_valid    = (cmd.note0 && (cnt_r != 2'd0)) || (cmd.note1 && (cnt_r == 2'd2));
  assign out_dest_ext = cmd.note1 ? n1_r.dest : n0_r.dest;
  assign out_tone     = cmd.note1 ? n1_r.tone : n0_r.tone;
  assign out_number   = cmd.note1 ? n1_r.num : n0_r.num;
  assign out_last     = cmd.note1 || (cnt_r == 2'd1);

  a_note_in_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (cmd.note0 || cmd.note1))
    else $error("notice outside a notice slot");

  a_second_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.note1 && out_valid) |-> out_last)
    else $error("second notice not marked last");

  a_last_ends_event: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |=> !out_valid)
    else $error("notice follows the last notice of an event");

  a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.note0 && cnt_r == 2'd2) |=> (out_valid && out_last))
    else $error("second notice of a pair missing");

endmodule

// File: hw/rtl/pbx_call_state_switch_core.sv
`timescale 1ns / 1ps

// Call controller for a table of telephone extensions.
// An event (op, unit, target) is transferred in at a rising edge where start
// is high and busy is low. busy stays high until the event is fully handled.
// Each event produces zero to two tone notices. A notice is on the out_ ports
// for exactly one cycle while out_valid is high; out_last marks the final
// notice of the event. The receiver cannot stall, so every notice is a
// transfer at the edge that ends its cycle.
// After the accepting edge the sequencer passes GET_U and GET_E; the first
// notice appears in NOTE0 and a second one follows in the next cycle, in
// NOTE1, which is used only when a second table entry is written or a
// second notice is sent. No new event is taken until the sequencer is back
// in idle. Events with an unknown op or a unit outside the table return to
// idle after GET_U. The table has one read and one write port: the issuing
// entry and the second entry (peer or dialed target) are read one after the
// other, and the two entries are written back in separate cycles.
// Reset (rst_n low, synchronous) returns the controller to idle and marks
// every table entry unwritten; unwritten entries read as unregistered, on
// hook and without a peer, so no clearing pass is needed.
module pbx_call_state_switch_core #(
  parameter int MAX_EXTENSIONS = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [pcss_pkg::OP_W-1:0]    in_op,
  input  logic [pcss_pkg::EXT_W-1:0]   in_unit,
  input  logic [pcss_pkg::EXT_W-1:0]   in_target,
  output logic                         out_valid,
  output logic [pcss_pkg::EXT_W-1:0]   out_dest_ext,
  output logic [pcss_pkg::TONE_W-1:0]  out_tone,
  output logic [pcss_pkg::EXT_W-1:0]   out_number,
  output logic                         out_last
);

  // Commands and status between the sequencer and the table datapath.
  pcss_pkg::cmd_t    cmd;
  pcss_pkg::status_t status;

  // The sequencer steps through read, plan and write-back of one event.
  pcss_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  // The datapath holds the extension table and works out the call logic.
  pcss_datapath #(
    .MAX_EXTENSIONS (MAX_EXTENSIONS)
  ) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .status       (status),
    .in_op        (in_op),
    .in_unit      (in_unit),
    .in_target    (in_target),
    .out_valid    (out_valid),
    .out_dest_ext (out_dest_ext),
    .out_tone     (out_tone),
    .out_number   (out_number),
    .out_last     (out_last)
  );

endmodule
